@@ hw/rtl/dqls_pkg.sv @@
// ---------------------------------------------------------------------------
// dqls_pkg
// Shared types and codes for the bounded deque with linear search.
// ---------------------------------------------------------------------------
`default_nettype none

package dqls_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int REQ_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int POS_OUT_W   = 4;
    localparam int FILL_OUT_W  = 5;
    localparam int OUT_FIELD_W = STATUS_W + VALUE_W + POS_OUT_W + FILL_OUT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH_FRONT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SEARCH_BACK  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR        = 3'd6;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the request
        logic exec;      // push, pop address, clear or scan setup
        logic pop_take;  // capture popped word
        logic scan;      // one scan step
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic exec_done;  // result final after exec
        logic exec_pop;   // a read of the store is in flight
        logic scan_done;  // match found or all entries compared
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/dqls_ctrl.sv @@
// ---------------------------------------------------------------------------
// dqls_ctrl
// Controller: sequences one request through exec, read, scan and result.
// ---------------------------------------------------------------------------
`default_nettype none

module dqls_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    input  dqls_pkg::t_dp_sts  i_sts,
    output dqls_pkg::t_dp_cmd  o_cmd
);
    import dqls_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_POPRD = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_o_valid;
    logic       n_o_valid;
    logic       out_free;

    assign out_free      = !r_o_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.exec_pop) begin
                    n_state = S_POPRD;
                end else if (i_sts.exec_done) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_POPRD: begin
                o_cmd.pop_take = 1'b1;
                n_state        = S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (o_cmd.out_load) begin
            n_o_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dqls_dp.sv @@
// ---------------------------------------------------------------------------
// dqls_dp
// Datapath: circular entry store, front pointer, fill count, scan unit
// and the output payload register.
// ---------------------------------------------------------------------------
`default_nettype none

module dqls_dp #(
    parameter int CAPACITY = dqls_pkg::DEFAULT_CAPACITY
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  dqls_pkg::t_dp_cmd                    i_cmd,
    output dqls_pkg::t_dp_sts                    o_sts,
    input  wire [dqls_pkg::REQ_W-1:0]            i_req_type,
    input  wire [dqls_pkg::VALUE_W-1:0]          i_value,
    output logic [dqls_pkg::OUT_TDATA_W-1:0]     o_tdata
);
    import dqls_pkg::*;

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic [REQ_W-1:0]          r_req;
    logic signed [VALUE_W-1:0] r_val;
    logic [PTR_W-1:0]          r_front;
    logic [CNT_W-1:0]          r_count;
    logic signed [VALUE_W-1:0] r_rd_data;

    logic [PTR_W-1:0]          r_idx;
    logic [CNT_W-1:0]          r_left;
    logic                      r_pend;
    logic [PTR_W-1:0]          r_pend_pos;

    logic [STATUS_W-1:0]       r_status;
    logic signed [VALUE_W-1:0] r_data;
    logic [PTR_W-1:0]          r_pos;
    logic [OUT_TDATA_W-1:0]    r_tdata;

    logic                      full;
    logic                      empty;
    logic                      is_push;
    logic                      is_pop;
    logic                      is_search;
    logic [PTR_W-1:0]          front_dec;
    logic [PTR_W-1:0]          count_lo;
    logic                      match;
    logic                      mem_we;
    logic [PTR_W-1:0]          mem_wa;
    logic                      mem_re;
    logic [PTR_W-1:0]          mem_ra;
    logic [POS_OUT_W+PTR_W-1:0] pos_ext;
    logic [FILL_OUT_W+CNT_W-1:0] fill_ext;

    // physical slot of a logical position, both below CAPACITY
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(CAPACITY)) begin
            sum = sum - (PTR_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign is_push   = r_req inside {REQ_PUSH_FRONT, REQ_PUSH_BACK};
    assign is_pop    = r_req inside {REQ_POP_FRONT, REQ_POP_BACK};
    assign is_search = r_req inside {REQ_SEARCH_FRONT, REQ_SEARCH_BACK};
    assign front_dec = (r_front == '0) ? PTR_W'(CAPACITY - 1) : r_front - PTR_W'(1);
    assign count_lo  = r_count[PTR_W-1:0];
    assign match     = r_pend && (r_rd_data == r_val);

    assign o_sts.exec_pop  = is_pop && !empty;
    assign o_sts.exec_done = !(is_pop && !empty) && !(is_search && !empty);
    assign o_sts.scan_done = match || (r_left == '0);

    always_comb begin
        mem_we = i_cmd.exec && is_push && !full;
        mem_wa = (r_req == REQ_PUSH_FRONT) ? front_dec : slot_of(r_front, count_lo);
        mem_re = 1'b0;
        mem_ra = slot_of(r_front, r_idx);
        if (i_cmd.exec) begin
            mem_re = is_pop && !empty;
            mem_ra = (r_req == REQ_POP_FRONT) ? r_front
                                              : slot_of(r_front, count_lo - PTR_W'(1));
        end else if (i_cmd.scan) begin
            mem_re = !match && (r_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= r_val;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            r_data <= '0;
            r_pos  <= '0;
            if (is_push && full) begin
                r_status <= ST_FULL;
            end else if (is_pop && empty) begin
                r_status <= ST_EMPTY;
            end else if (is_search) begin
                r_status <= ST_NOTFOUND;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.pop_take) begin
            r_data <= r_rd_data;
        end
        if (i_cmd.scan && match) begin
            r_status <= ST_OK;
            r_data   <= r_val;
            r_pos    <= r_pend_pos;
        end
        if (i_cmd.out_load) begin
            r_tdata <= {{PAD_W{1'b0}}, fill_ext[FILL_OUT_W-1:0],
                        pos_ext[POS_OUT_W-1:0], r_data, r_status};
        end
    end

    // queue pointers and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_left     <= '0;
            r_pend     <= 1'b0;
            r_pend_pos <= '0;
        end else if (i_cmd.exec) begin
            r_pend <= 1'b0;
            case (r_req)
                REQ_PUSH_FRONT: begin
                    if (!full) begin
                        r_front <= front_dec;
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                REQ_PUSH_BACK: begin
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                REQ_POP_FRONT: begin
                    if (!empty) begin
                        r_front <= slot_of(r_front, PTR_W'(1));
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                REQ_POP_BACK: begin
                    if (!empty) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                REQ_SEARCH_FRONT: begin
                    r_left <= r_count;
                    r_idx  <= '0;
                end
                REQ_SEARCH_BACK: begin
                    r_left <= r_count;
                    r_idx  <= count_lo - PTR_W'(1);
                end
                REQ_CLEAR: begin
                    r_front <= '0;
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.scan) begin
            if (match) begin
                r_pend <= 1'b0;
            end else if (r_left != '0) begin
                // issue the next read, compare it on the following cycle
                r_pend     <= 1'b1;
                r_pend_pos <= r_idx;
                r_left     <= r_left - CNT_W'(1);
                if (r_req == REQ_SEARCH_BACK) begin
                    r_idx <= r_idx - PTR_W'(1);
                end else begin
                    r_idx <= r_idx + PTR_W'(1);
                end
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    assign pos_ext  = {{POS_OUT_W{1'b0}}, r_pos};
    assign fill_ext = {{FILL_OUT_W{1'b0}}, r_count};
    assign o_tdata  = r_tdata;

endmodule

`default_nettype wire

@@ hw/rtl/deque_with_linear_search.sv @@
// ---------------------------------------------------------------------------
// deque_with_linear_search
// Bounded double-ended queue of signed 32-bit words with push, pop,
// search from either end and clear.
//
//  channel  dir  tdata (low bit up)                                  tuser
//  s_axis   in   value[31:0]                                         req_type[2:0]
//  m_axis   out  status[1:0] data_out[33:2] match_position[37:34]    -
//                fill_level[42:38] zero[47:43]
//
// Push, clear, unused and refused requests and searches of an empty queue
// go from accept through exec straight to the result state, pops pass
// through a store read first; a search reads one entry per cycle through
// the store's single read port and compares at most CAPACITY entries.
// Reset empties the queue; the store itself is not cleared.
// A stalled result sits in the output register; the next request is
// taken once the current one has been handed to that register.
// ---------------------------------------------------------------------------
`default_nettype none

module deque_with_linear_search #(
    parameter int CAPACITY = dqls_pkg::DEFAULT_CAPACITY
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire [dqls_pkg::VALUE_W-1:0]       s_axis_tdata,   // value
    input  wire [dqls_pkg::REQ_W-1:0]         s_axis_tuser,   // req_type
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // status, data_out, match_position, fill_level, zero pad
    output logic [dqls_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import dqls_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dqls_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    dqls_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req_type (s_axis_tuser),
        .i_value    (s_axis_tdata),
        .o_tdata    (m_axis_tdata)
    );

endmodule

`default_nettype wire
